>>> hw/rtl/sbad_pkg.sv
// Shared types, constants and the IMA step sizes for the stereo block ADPCM decoder.
// No dependencies; imported by sbad_nibble, the top level and the bench.
package sbad_pkg;

	localparam int unsigned IDX_MAX = 88;

	// Header positions: bytes 0..9, then packed data
	localparam logic [3:0] POS_FIRST  = 4'd0;
	localparam logic [3:0] POS_CNT_HI = 4'd1;
	localparam logic [3:0] POS_LP_LO  = 4'd2;
	localparam logic [3:0] POS_LP_HI  = 4'd3;
	localparam logic [3:0] POS_LIDX   = 4'd4;
	localparam logic [3:0] POS_RP_LO  = 4'd6;
	localparam logic [3:0] POS_RP_HI  = 4'd7;
	localparam logic [3:0] POS_RIDX   = 4'd8;
	localparam logic [3:0] POS_LAST   = 4'd9;
	localparam logic [3:0] POS_DATA   = 4'd10;

	localparam logic [15:0] MAX_FRAMES_RST = 16'd4096;

	localparam logic [7:0] IDX_MAX_B = 8'(IDX_MAX);

	typedef logic [6:0] step_idx_t;

	// IMA ADPCM quantizer step sizes
	localparam logic [14:0] IMA_STEP_SIZES [0:IDX_MAX] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
		15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794, 15'd32767
	};

	// One decoded stereo frame as it leaves the block
	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic               block_begin;
		logic               header_error;
	} frame_t;

endpackage

>>> hw/rtl/sbad_ifs.sv
// Valid/ready channel interfaces for the stereo block ADPCM decoder.
// Depends on nothing; used by the top level and its instantiating environment.
interface sbad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_start;
	modport source (output valid, output data_byte, output track_start, input ready);
	modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface sbad_frame_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               block_begin;
	logic               header_error;
	modport source (output valid, output left_sample, output right_sample,
		output block_begin, output header_error, input ready);
	modport sink   (input valid, input left_sample, input right_sample,
		input block_begin, input header_error, output ready);
endinterface

interface sbad_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/sbad_nibble.sv
// One channel of IMA ADPCM nibble decode: step lookup, shift-add, clamps.
// Depends on sbad_pkg for the step sizes.
module sbad_nibble (
	input  logic signed [15:0] pred,
	input  logic [7:0]         idx,
	input  logic [3:0]         code,
	output logic signed [15:0] sample,
	output logic [7:0]         idx_next
);
	import sbad_pkg::*;

	step_idx_t          idx_c;
	logic [14:0]        step;
	logic [15:0]        diff;
	logic signed [17:0] sum;
	logic signed [8:0]  idx_sum;
	logic signed [8:0]  adj;

	// Clamp stored index, then build the difference from the step
	always_comb begin
		idx_c = (idx > IDX_MAX_B) ? step_idx_t'(IDX_MAX) : idx[6:0];
		step  = IMA_STEP_SIZES[idx_c];
		diff  = {4'd0, step[14:3]};
		if (code[0]) diff = diff + {3'd0, step[14:2]};
		if (code[1]) diff = diff + {2'd0, step[14:1]};
		if (code[2]) diff = diff + {1'b0, step};
	end

	// Predictor update with 16-bit saturation
	always_comb begin
		if (code[3]) sum = {{2{pred[15]}}, pred} - $signed({2'b00, diff});
		else         sum = {{2{pred[15]}}, pred} + $signed({2'b00, diff});
		if (sum > 18'sd32767)       sample = 16'sh7fff;
		else if (sum < -18'sd32768) sample = 16'sh8000;
		else                        sample = sum[15:0];
	end

	// Index adaptation, clamped to the table range
	always_comb begin
		case (code[2:0])
			3'd4:    adj = 9'sd2;
			3'd5:    adj = 9'sd4;
			3'd6:    adj = 9'sd6;
			3'd7:    adj = 9'sd8;
			default: adj = -9'sd1;
		endcase
		idx_sum = $signed({2'b00, idx_c}) + adj;
		if (idx_sum < 9'sd0)                   idx_next = 8'd0;
		else if (idx_sum > $signed({1'b0, IDX_MAX_B})) idx_next = IDX_MAX_B;
		else                                   idx_next = idx_sum[7:0];
	end

endmodule

>>> hw/rtl/stereo_block_adpcm_decoder_top.sv
// Stereo block ADPCM decoder: input register, header parser and two nibble decoders,
// result register. Depends on sbad_pkg, sbad_ifs and sbad_nibble.
// An accepted byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle unless a stalled output holds the result register.
// Reset (arst_n low): parser at header byte 0, predictors and indices zero,
// max_block_frames 4096, both pipeline registers empty.
module stereo_block_adpcm_decoder_top (
	input logic         clk,
	input logic         arst_n,
	sbad_byte_if.sink   byte_ch,
	sbad_frame_if.source frame_ch,
	sbad_cfg_if.sink    cfg
);
	import sbad_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        valid_s2;
	frame_t      frame_s2;

	logic [15:0] max_frames_q;
	logic [3:0]  pos_q;
	logic [15:0] frames_q;
	logic [15:0] lpred_q;
	logic [15:0] rpred_q;
	logic [7:0]  lidx_q;
	logic [7:0]  ridx_q;

	logic        out_free;
	logic        advance;
	logic [3:0]  pos_eff;
	logic [3:0]  pos_n;
	logic [15:0] frames_n;
	logic [15:0] lpred_n;
	logic [15:0] rpred_n;
	logic [7:0]  lidx_n;
	logic [7:0]  ridx_n;
	logic        has_out;
	frame_t      frame_n;
	logic        bad;
	logic signed [15:0] ldec;
	logic signed [15:0] rdec;
	logic [7:0]  lidx_dec;
	logic [7:0]  ridx_dec;

	assign out_free     = !valid_s2 || frame_ch.ready;
	assign advance      = valid_s1 && out_free;
	assign byte_ch.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	sbad_nibble u_left (
		.pred(lpred_q), .idx(lidx_q), .code(byte_s1[3:0]),
		.sample(ldec), .idx_next(lidx_dec)
	);
	sbad_nibble u_right (
		.pred(rpred_q), .idx(ridx_q), .code(byte_s1[7:4]),
		.sample(rdec), .idx_next(ridx_dec)
	);

	// Parser: next state and result for the byte held in the input register
	always_comb begin
		pos_eff  = (start_s1 || pos_q > POS_DATA || (pos_q == POS_DATA && frames_q == '0))
			? POS_FIRST : pos_q;
		pos_n    = pos_eff;
		frames_n = frames_q;
		lpred_n  = lpred_q;
		rpred_n  = rpred_q;
		lidx_n   = lidx_q;
		ridx_n   = ridx_q;
		has_out  = 1'b0;
		frame_n  = '0;
		bad      = 1'b0;
		if (pos_eff == POS_DATA) begin
			lpred_n  = ldec;
			rpred_n  = rdec;
			lidx_n   = lidx_dec;
			ridx_n   = ridx_dec;
			frames_n = frames_q - 16'd1;
			if (frames_n == '0) pos_n = POS_FIRST;
			has_out  = 1'b1;
			frame_n.left_sample  = ldec;
			frame_n.right_sample = rdec;
		end else begin
			case (pos_eff)
				POS_FIRST:  frames_n = {8'd0, byte_s1};
				POS_CNT_HI: frames_n = {byte_s1, frames_q[7:0]};
				POS_LP_LO:  lpred_n  = {lpred_q[15:8], byte_s1};
				POS_LP_HI:  lpred_n  = {byte_s1, lpred_q[7:0]};
				POS_LIDX:   lidx_n   = byte_s1;
				POS_RP_LO:  rpred_n  = {rpred_q[15:8], byte_s1};
				POS_RP_HI:  rpred_n  = {byte_s1, rpred_q[7:0]};
				POS_RIDX:   ridx_n   = byte_s1;
				default:    ;
			endcase
			if (pos_eff < POS_LAST) begin
				pos_n = pos_eff + 4'd1;
			end else begin
				has_out = 1'b1;
				bad = frames_q == '0 || frames_q > max_frames_q ||
					lidx_q > IDX_MAX_B || ridx_q > IDX_MAX_B;
				if (bad) begin
					frames_n = '0;
					pos_n    = POS_FIRST;
					frame_n.header_error = 1'b1;
				end else begin
					frames_n = frames_q - 16'd1;
					pos_n    = (frames_n != '0) ? POS_DATA : POS_FIRST;
					frame_n.left_sample  = lpred_q;
					frame_n.right_sample = rpred_q;
					frame_n.block_begin  = 1'b1;
				end
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1  <= byte_ch.data_byte;
			start_s1 <= byte_ch.track_start;
		end
	end

	// Parser state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frames_q <= MAX_FRAMES_RST;
			pos_q        <= POS_FIRST;
			frames_q     <= '0;
			lpred_q      <= '0;
			rpred_q      <= '0;
			lidx_q       <= '0;
			ridx_q       <= '0;
		end else begin
			if (cfg.valid) max_frames_q <= cfg.data;
			if (advance) begin
				pos_q    <= pos_n;
				frames_q <= frames_n;
				lpred_q  <= lpred_n;
				rpred_q  <= rpred_n;
				lidx_q   <= lidx_n;
				ridx_q   <= ridx_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && has_out;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_out) frame_s2 <= frame_n;
	end

	assign frame_ch.valid        = valid_s2;
	assign frame_ch.left_sample  = frame_s2.left_sample;
	assign frame_ch.right_sample = frame_s2.right_sample;
	assign frame_ch.block_begin  = frame_s2.block_begin;
	assign frame_ch.header_error = frame_s2.header_error;

endmodule

>>> hw/rtl/sbad_checker.sv
// Port-level checks for the stereo block ADPCM decoder output channel.
// Bound to stereo_block_adpcm_decoder_top; no package dependency.
module sbad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] left_sample,
	input logic signed [15:0] right_sample,
	input logic               block_begin,
	input logic               header_error
);

	// A stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_sample) &&
		$stable(right_sample) && $stable(block_begin) && $stable(header_error))
		else $error("output payload changed while stalled");

	// An error frame is silent and never a block start
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_error |-> left_sample == 16'sd0 && right_sample == 16'sd0)
		else $error("header error frame carries nonzero samples");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(block_begin && header_error))
		else $error("block_begin and header_error both set");

endmodule

bind stereo_block_adpcm_decoder_top sbad_checker u_sbad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (frame_ch.valid),
	.out_ready    (frame_ch.ready),
	.left_sample  (frame_ch.left_sample),
	.right_sample (frame_ch.right_sample),
	.block_begin  (frame_ch.block_begin),
	.header_error (frame_ch.header_error)
);

>>> bench/stereo_block_adpcm_decoder_top_tb.sv
// Self-checking bench for the stereo block ADPCM decoder: byte tracks in, stereo frames out,
// each frame checked against an in-bench IMA ADPCM decoder model.
// Depends on sbad_pkg, sbad_ifs and the stereo_block_adpcm_decoder_top RTL.
module stereo_block_adpcm_decoder_top_tb;
	import sbad_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int PIPE_SETTLE    = 6;
	localparam int PHASE_BYTES    = 450;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
	} track_byte_t;

	typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	sbad_byte_if  byte_ch ();
	sbad_frame_if frame_ch ();
	sbad_cfg_if   cfg ();

	stereo_block_adpcm_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.frame_ch (frame_ch),
		.cfg      (cfg)
	);

	always #2 clk = ~clk;

	// Decoder model state
	logic [3:0]  m_pos;
	logic [15:0] m_frames;
	logic [15:0] m_lpred, m_rpred;
	logic [7:0]  m_lidx, m_ridx;
	logic [15:0] m_max_frames;

	frame_t      frames_due[$];
	track_byte_t track_q[$];

	int errors = 0;
	int frames_checked = 0;
	int seeds_seen = 0;
	int header_errors_seen = 0;
	int bytes_sent = 0;
	int settings_used = 0;
	int rx_hold_req = 0;
	bit in_sync = 1'b1;

	// One IMA ADPCM nibble: updates predictor and step index, returns new sample
	function automatic logic [15:0] ima_code_decode(input logic [3:0] code,
			inout logic [15:0] pred, inout logic [7:0] idx);
		int unsigned i;
		int step, diff, sample, ni;
		i = (idx > IDX_MAX) ? IDX_MAX : idx;
		step = int'(IMA_STEP_SIZES[i]);
		diff = step >> 3;
		if (code[0]) diff += step >> 2;
		if (code[1]) diff += step >> 1;
		if (code[2]) diff += step;
		sample = int'($signed(pred)) + (code[3] ? -diff : diff);
		if (sample > 32767) sample = 32767;
		if (sample < -32768) sample = -32768;
		ni = int'(i) + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
		if (ni < 0) ni = 0;
		if (ni > int'(IDX_MAX)) ni = IDX_MAX;
		idx = 8'(ni);
		pred = 16'(sample);
		return pred;
	endfunction

	// Advance the model by one byte; returns 1 when a frame is due
	function automatic bit decode_byte(input logic [7:0] b, input logic st, output frame_t f);
		bit bad;
		f = '0;
		if (st || m_pos > POS_DATA || (m_pos == POS_DATA && m_frames == 16'd0))
			m_pos = POS_FIRST;
		if (m_pos == POS_DATA) begin
			f.left_sample  = ima_code_decode(b[3:0], m_lpred, m_lidx);
			f.right_sample = ima_code_decode(b[7:4], m_rpred, m_ridx);
			m_frames--;
			if (m_frames == 16'd0) m_pos = POS_FIRST;
			return 1'b1;
		end
		case (m_pos)
			POS_FIRST:  m_frames = {8'h00, b};
			POS_CNT_HI: m_frames = {b, m_frames[7:0]};
			POS_LP_LO:  m_lpred[7:0] = b;
			POS_LP_HI:  m_lpred[15:8] = b;
			POS_LIDX:   m_lidx = b;
			POS_RP_LO:  m_rpred[7:0] = b;
			POS_RP_HI:  m_rpred[15:8] = b;
			POS_RIDX:   m_ridx = b;
			default: ;
		endcase
		if (m_pos < POS_LAST) begin
			m_pos++;
			return 1'b0;
		end
		bad = m_frames == 16'd0 || m_frames > m_max_frames ||
			m_lidx > IDX_MAX_B || m_ridx > IDX_MAX_B;
		if (bad) begin
			m_frames = 16'd0;
			m_pos = POS_FIRST;
			f.header_error = 1'b1;
			return 1'b1;
		end
		f.left_sample  = m_lpred;
		f.right_sample = m_rpred;
		f.block_begin  = 1'b1;
		m_frames--;
		m_pos = (m_frames != 16'd0) ? POS_DATA : POS_FIRST;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Output check first, then prediction of the byte accepted at this edge
	always @(posedge clk) begin : frame_monitor
		frame_t want, pred_f;
		if (!arst_n) begin
			m_pos = POS_FIRST;
			m_frames = '0;
			m_lpred = '0;
			m_rpred = '0;
			m_lidx = '0;
			m_ridx = '0;
			m_max_frames = MAX_FRAMES_RST;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				frames_checked++;
				if (frame_ch.block_begin) seeds_seen++;
				if (frame_ch.header_error) header_errors_seen++;
				if (frames_due.size() == 0) begin
					$error("frame with no expectation: L=%0d R=%0d begin=%0b err=%0b",
						frame_ch.left_sample, frame_ch.right_sample,
						frame_ch.block_begin, frame_ch.header_error);
					errors++;
				end else begin
					want = frames_due.pop_front();
					check_field("left_sample", int'($signed(want.left_sample)),
						int'($signed(frame_ch.left_sample)));
					check_field("right_sample", int'($signed(want.right_sample)),
						int'($signed(frame_ch.right_sample)));
					check_field("block_begin", int'(want.block_begin),
						int'(frame_ch.block_begin));
					check_field("header_error", int'(want.header_error),
						int'(frame_ch.header_error));
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				if (decode_byte(byte_ch.data_byte, byte_ch.track_start, pred_f))
					frames_due.push_back(pred_f);
			end
			if (cfg.valid && cfg.ready) m_max_frames = cfg.data;
		end
	end

	// Receiver: randomly chosen stall modes that change at random, plus requested hold-offs
	initial begin : rx_stall_gen
		rx_mode_e mode;
		int mode_left, hold_left, hold_seen, phase;
		frame_ch.ready <= 1'b0;
		mode = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != rx_hold_req) begin
				hold_seen = rx_hold_req;
				hold_left = RX_HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				frame_ch.ready <= 1'b0;
			end else begin
				case (mode)
					RX_STEADY:  frame_ch.ready <= 1'b1;
					RX_COIN:    frame_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:  frame_ch.ready <= ($urandom_range(0, 3) == 0);
					RX_CADENCE: frame_ch.ready <= (phase % 3 != 0);
				endcase
			end
		end
	end

	// Run watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one byte and hold it until the transaction completes; valid stays high
	task automatic send_byte(input track_byte_t it);
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= it.data_byte;
		byte_ch.track_start <= it.track_start;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	// Send the queued track, in random bursts when paced
	task automatic stream_queued_bytes(input bit paced);
		int burst;
		burst = 0;
		while (track_q.size() != 0) begin
			if (burst == 0) begin
				if (paced && $urandom_range(0, 2) != 0) begin
					byte_ch.valid       <= 1'b0;
					byte_ch.data_byte   <= 8'($urandom);
					byte_ch.track_start <= 1'($urandom);
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
			send_byte(track_q.pop_front());
			burst--;
		end
	endtask

	// Stop sending and wait until the block has nothing left in flight
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (frames_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_max_frames(input logic [15:0] value);
		settle();
		cfg.data  <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic st);
		track_q.push_back('{b, st});
	endtask

	task automatic add_header(input logic [15:0] count, input logic [15:0] lp,
			input logic [7:0] li, input logic [15:0] rp, input logic [7:0] ri,
			input logic st);
		queue_byte(count[7:0], st);
		queue_byte(count[15:8], 1'b0);
		queue_byte(lp[7:0], 1'b0);
		queue_byte(lp[15:8], 1'b0);
		queue_byte(li, 1'b0);
		queue_byte(8'($urandom), 1'b0);
		queue_byte(rp[7:0], 1'b0);
		queue_byte(rp[15:8], 1'b0);
		queue_byte(ri, 1'b0);
		queue_byte(8'($urandom), 1'b0);
	endtask

	task automatic add_data(input int n);
		repeat (n) queue_byte(8'($urandom), 1'b0);
	endtask

	// Mostly well-formed blocks, some truncated, bad headers and loose noise
	task automatic add_random_block(input int limit);
		int pick, count, sent;
		logic st;
		logic [7:0] li, ri;
		st = in_sync ? 1'($urandom_range(0, 1)) : 1'b1;
		in_sync = 1'b1;
		pick = $urandom_range(0, 99);
		li = 8'($urandom_range(0, IDX_MAX));
		ri = 8'($urandom_range(0, IDX_MAX));
		if (pick < 70) begin
			count = $urandom_range(1, (limit < 32) ? limit : 32);
			add_header(16'(count), 16'($urandom), li, 16'($urandom), ri, st);
			add_data(count - 1);
		end else if (pick < 78) begin
			// declared count may run far past what is sent; track_start cuts it
			count = $urandom_range(1, limit);
			sent = $urandom_range(0, 12);
			if (sent > count - 1) sent = count - 1;
			add_header(16'(count), 16'($urandom), li, 16'($urandom), ri, st);
			add_data(sent);
			in_sync = (sent == count - 1);
		end else if (pick < 86) begin
			if (limit < 65535 && $urandom_range(0, 1) == 1) begin
				count = limit + 1 + $urandom_range(0, 3);
				if (count > 65535) count = 65535;
			end else begin
				count = 0;
			end
			add_header(16'(count), 16'($urandom), li, 16'($urandom), ri, st);
		end else if (pick < 94) begin
			count = $urandom_range(1, (limit < 32) ? limit : 32);
			case ($urandom_range(0, 2))
				0: li = 8'($urandom_range(IDX_MAX + 1, 255));
				1: ri = 8'($urandom_range(IDX_MAX + 1, 255));
				default: begin
					li = 8'($urandom_range(IDX_MAX + 1, 255));
					ri = 8'($urandom_range(IDX_MAX + 1, 255));
				end
			endcase
			add_header(16'(count), 16'($urandom), li, 16'($urandom), ri, st);
			add_data(count - 1);
		end else begin
			repeat ($urandom_range(1, 12))
				queue_byte(8'($urandom), ($urandom_range(0, 3) == 0));
			in_sync = 1'b0;
		end
	endtask

	// Seeds at full scale, decodes that clamp both ways, zero and out-of-range headers
	task automatic test_clamp_extremes();
		add_header(16'd3, 16'h7FFF, IDX_MAX_B, 16'h8000, IDX_MAX_B, 1'b1);
		queue_byte(8'h87, 1'b0);
		queue_byte(8'h78, 1'b0);
		add_header(16'd0, 16'h1234, 8'd10, 16'hFEDC, 8'd20, 1'b0);
		add_header(16'd2, 16'h0000, 8'd0, 16'h0000, 8'hFF, 1'b0);
		stream_queued_bytes(1'b0);
		in_sync = 1'b1;
	endtask

	// Frame count against the register: one-frame blocks, limit edges, register at zero
	task automatic test_frame_limit();
		write_max_frames(16'd1);
		add_header(16'd1, 16'h0100, 8'd5, 16'hFF00, 8'd6, 1'b1);
		add_header(16'd2, 16'h0001, 8'd5, 16'h0002, 8'd6, 1'b0);
		stream_queued_bytes(1'b1);
		write_max_frames(16'd0);
		add_header(16'd1, 16'h0000, 8'd0, 16'h0000, 8'd0, 1'b1);
		stream_queued_bytes(1'b1);
		write_max_frames(16'hFFFF);
		add_header(16'hFFFF, 16'h5555, 8'd0, 16'hAAAA, 8'd0, 1'b1);
		add_data(6);
		add_header(16'd4, 16'h0000, 8'd89, 16'h0000, 8'd0, 1'b1);
		add_header(16'd2, 16'h8001, 8'd44, 16'h7FFE, 8'd44, 1'b0);
		add_data(1);
		stream_queued_bytes(1'b1);
		write_max_frames(MAX_FRAMES_RST);
		add_header(16'd4097, 16'h0000, 8'd1, 16'h0000, 8'd1, 1'b1);
		add_header(16'd4096, 16'h0F0F, 8'd30, 16'hF0F0, 8'd60, 1'b0);
		add_data(3);
		stream_queued_bytes(1'b1);
		in_sync = 1'b0;
	endtask

	// track_start in the middle of a header and in the middle of a block
	task automatic test_restart();
		queue_byte(8'h05, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h33, 1'b0);
		queue_byte(8'h44, 1'b0);
		add_header(16'd5, 16'hC000, 8'd70, 16'h4000, 8'd12, 1'b1);
		add_data(2);
		add_header(16'd2, 16'h0000, 8'd88, 16'h0000, 8'd0, 1'b1);
		add_data(1);
		stream_queued_bytes(1'b1);
		in_sync = 1'b1;
	endtask

	// Long receiver hold-off while the sender keeps offering bytes
	task automatic test_receiver_holdoff();
		rx_hold_req++;
		add_header(16'd40, 16'($urandom), 8'd40, 16'($urandom), 8'd50, 1'b1);
		add_data(39);
		stream_queued_bytes(1'b0);
		settle();
		in_sync = 1'b1;
	endtask

	// Sender pauses mid-block until every pending frame has come out
	task automatic test_drain_pause();
		add_header(16'd20, 16'($urandom), 8'd15, 16'($urandom), 8'd75, 1'b1);
		add_data(5);
		stream_queued_bytes(1'b1);
		settle();
		add_data(14);
		stream_queued_bytes(1'b1);
		in_sync = 1'b1;
	endtask

	task automatic test_random_phase(input logic [15:0] limit);
		write_max_frames(limit);
		while (track_q.size() < PHASE_BYTES) add_random_block(int'(limit));
		stream_queued_bytes(1'b1);
	endtask

	initial begin
		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.data_byte   <= '0;
		byte_ch.track_start <= 1'b0;
		cfg.valid           <= 1'b0;
		cfg.data            <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_clamp_extremes();
		test_frame_limit();
		test_restart();
		test_receiver_holdoff();
		test_drain_pause();
		test_random_phase(16'($urandom_range(1, 40)));
		test_random_phase(16'hFFFF);
		test_random_phase(MAX_FRAMES_RST);
		test_random_phase(16'($urandom_range(2, 8)));
		settle();

		$display("Sent %0d bytes under %0d register settings; checked %0d frames",
			bytes_sent, settings_used, frames_checked);
		$display("(%0d block seeds, %0d header errors)", seeds_seen, header_errors_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sbad_pkg.sv
hw/rtl/sbad_ifs.sv
hw/rtl/sbad_nibble.sv
hw/rtl/stereo_block_adpcm_decoder_top.sv
hw/rtl/sbad_checker.sv
bench/stereo_block_adpcm_decoder_top_tb.sv
